// ===== rtl/tsrs_pkg.sv =====
// Package for the time slotted ring store: widths, codes, reset values and
// the request and response types of the shared divider. No dependencies.
package tsrs_pkg;

	localparam int SLOTS      = 64;
	localparam int POS_W      = $clog2(SLOTS);
	localparam int RING_W     = 7;
	localparam int IVL_W      = 16;
	localparam int TIME_BITS  = 32;
	localparam int WORD_W     = 64;
	localparam int STAT_W     = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam int WIN_W      = POS_W + IVL_W;
	localparam int SUM_W      = RING_W + 1;
	localparam int DIV_CNT_W  = $clog2(TIME_BITS);

	localparam logic [RING_W-1:0] RING_SIZE_RST = RING_W'(64);
	localparam logic [IVL_W-1:0]  SLOT_IVL_RST  = IVL_W'(300);

	localparam logic OP_STORE  = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_RING_SIZE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_SLOT_IVL  = CFG_IDX_W'(1);

	typedef enum logic [STAT_W-1:0] {
		ST_STORED  = 2'd0,
		ST_TOO_OLD = 2'd1,
		ST_FOUND   = 2'd2,
		ST_MISS    = 2'd3
	} status_t;

	typedef struct packed {
		logic                 start;
		logic [TIME_BITS-1:0] dividend;
		logic [IVL_W-1:0]     divisor;
	} div_req_t;

	typedef struct packed {
		logic                 busy;
		logic                 done;
		logic [TIME_BITS-1:0] quotient;
		logic [IVL_W-1:0]     remainder;
	} div_rsp_t;

endpackage

// ===== rtl/tsrs_ifs.sv =====
// Valid/ready channel interfaces for the input items and the result items.
// Depends on tsrs_pkg for the field widths.
interface tsrs_in_if;
	logic                           valid;
	logic                           ready;
	logic                           opcode;
	logic [tsrs_pkg::TIME_BITS-1:0] sample_time;
	logic [tsrs_pkg::WORD_W-1:0]    sample_value;

	modport source (output valid, opcode, sample_time, sample_value, input ready);
	modport sink (input valid, opcode, sample_time, sample_value, output ready);
endinterface

interface tsrs_out_if;
	logic                        valid;
	logic                        ready;
	logic [tsrs_pkg::STAT_W-1:0] status;
	logic [tsrs_pkg::WORD_W-1:0] value_out;

	modport source (output valid, status, value_out, input ready);
	modport sink (input valid, status, value_out, output ready);
endinterface

// ===== rtl/time_slotted_ring_store.sv =====
// Top level of the time slotted ring store: sequencer, slot valid bits,
// slot memories and the shared divider. Depends on tsrs_pkg, tsrs_ifs,
// tsrs_ram and tsrs_div.
//
// Items enter on item_in (valid/ready) and each gives exactly one result on
// item_out. A store places a timestamped word in the ring of time slots; a
// lookup returns the word held for exactly the requested time. The two
// configuration registers are written through cfg_we, cfg_index and cfg_data;
// the user must write them only while the block is idle; the block itself does not enforce this.
// The block takes one item at a time. An item on an empty ring, or a store
// rejected as too old, gets its result without the two step divisions. Every
// other item runs them as two passes of the shared divider (time step by slot
// interval, then slot step by ring size); a store then walks the stale
// slots, min(step, ring_size) of them, or none for a zero or backward
// step. A shrunk ring size adds one more divider pass to the next item.
// The result sits in an output register; the next item is accepted as soon
// as the result is loaded, even while the receiver stalls, and the following
// result waits until the held one is taken.
// Reset clears all valid bits, the last position and the registers to their
// defaults; no memory clearing pass is needed.
module time_slotted_ring_store (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [tsrs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tsrs_pkg::CFG_DATA_W-1:0] cfg_data,
	tsrs_in_if.sink                         item_in,
	tsrs_out_if.source                      item_out
);

	typedef enum logic [11:0] {
		S_IDLE   = 12'b0000_0000_0001,
		S_NORM   = 12'b0000_0000_0010,
		S_MODL   = 12'b0000_0000_0100,
		S_RDLAST = 12'b0000_0000_1000,
		S_LASTT  = 12'b0000_0001_0000,
		S_CALC   = 12'b0000_0010_0000,
		S_DIV1   = 12'b0000_0100_0000,
		S_DIV2   = 12'b0000_1000_0000,
		S_POS    = 12'b0001_0000_0000,
		S_WALK   = 12'b0010_0000_0000,
		S_WRITE  = 12'b0100_0000_0000,
		S_LKCHK  = 12'b1000_0000_0000
	} state_t;

	state_t                          state_q;
	logic [tsrs_pkg::RING_W-1:0]     ring_size_q;
	logic [tsrs_pkg::IVL_W-1:0]      slot_ivl_q;
	logic                            op_q;
	logic [tsrs_pkg::TIME_BITS-1:0]  t_q;
	logic [tsrs_pkg::WORD_W-1:0]     v_q;
	logic [tsrs_pkg::POS_W-1:0]      last_q;
	logic                            has_q;
	logic [tsrs_pkg::SLOTS-1:0]      valid_q;
	logic [tsrs_pkg::TIME_BITS-1:0]  last_t_q;
	logic [tsrs_pkg::WIN_W-1:0]      window_q;
	logic [tsrs_pkg::TIME_BITS-1:0]  min_t_q;
	logic                            neg_q;
	logic [tsrs_pkg::TIME_BITS-1:0]  mag_q;
	logic [tsrs_pkg::POS_W-1:0]      pos_q;
	logic [tsrs_pkg::RING_W-1:0]     walk_cnt_q;
	logic [tsrs_pkg::POS_W-1:0]      walk_p_q;
	logic                            rd_pend_s1;
	logic [tsrs_pkg::POS_W-1:0]      rd_addr_s1;
	logic                            out_valid_q;
	tsrs_pkg::status_t               out_status_q;
	logic [tsrs_pkg::WORD_W-1:0]     out_value_q;

	logic [tsrs_pkg::RING_W-1:0]     ring_eff;
	logic [tsrs_pkg::IVL_W-1:0]      ivl_eff;
	logic [tsrs_pkg::POS_W-1:0]      ring_m1;
	logic [tsrs_pkg::WIN_W-1:0]      win_prod;
	logic [tsrs_pkg::TIME_BITS-1:0]  diff;
	logic [tsrs_pkg::TIME_BITS-1:0]  step_mag;
	logic [tsrs_pkg::TIME_BITS-1:0]  ref_t;
	logic [tsrs_pkg::TIME_BITS-1:0]  win_x;
	logic [tsrs_pkg::TIME_BITS-1:0]  min_t;
	logic                            too_old;
	logic [tsrs_pkg::SUM_W-1:0]      base_x;
	logic [tsrs_pkg::SUM_W-1:0]      ring_x;
	logic [tsrs_pkg::SUM_W-1:0]      rem_x;
	logic [tsrs_pkg::SUM_W-1:0]      pos_sum;
	logic [tsrs_pkg::SUM_W-1:0]      pos_red;
	logic [tsrs_pkg::POS_W-1:0]      pos_next;
	logic [tsrs_pkg::RING_W-1:0]     walk_len;
	logic [tsrs_pkg::POS_W-1:0]      walk_p_next;
	logic                            out_free;
	logic                            empty_ring;

	logic [tsrs_pkg::POS_W-1:0]      ram_raddr;
	logic [tsrs_pkg::POS_W-1:0]      ram_waddr;
	logic                            ram_we;
	logic [tsrs_pkg::TIME_BITS-1:0]  tm_rdata;
	logic [tsrs_pkg::WORD_W-1:0]     wd_rdata;

	tsrs_pkg::div_req_t              div_req;
	tsrs_pkg::div_rsp_t              div_rsp;

	assign ring_eff = (ring_size_q == '0) ? tsrs_pkg::RING_W'(1) :
		((ring_size_q > tsrs_pkg::RING_W'(tsrs_pkg::SLOTS)) ?
		tsrs_pkg::RING_W'(tsrs_pkg::SLOTS) : ring_size_q);
	assign ivl_eff  = (slot_ivl_q == '0) ? tsrs_pkg::IVL_W'(1) : slot_ivl_q;
	assign ring_m1  = tsrs_pkg::POS_W'(ring_eff - tsrs_pkg::RING_W'(1));
	assign win_prod = {{tsrs_pkg::IVL_W{1'b0}}, ring_m1} *
		{{tsrs_pkg::POS_W{1'b0}}, ivl_eff};

	assign diff     = t_q - last_t_q;
	assign step_mag = diff[tsrs_pkg::TIME_BITS-1] ? (~diff + 1'b1) : diff;
	assign ref_t    = (t_q > last_t_q) ? t_q : last_t_q;
	assign win_x    = tsrs_pkg::TIME_BITS'(window_q);
	assign min_t    = (ref_t < win_x) ? '0 : (ref_t - win_x);
	assign too_old  = (op_q == tsrs_pkg::OP_STORE) && (t_q <= last_t_q) && (min_t >= t_q);

	assign base_x   = tsrs_pkg::SUM_W'(last_q);
	assign ring_x   = tsrs_pkg::SUM_W'(ring_eff);
	assign rem_x    = tsrs_pkg::SUM_W'(div_rsp.remainder[tsrs_pkg::POS_W-1:0]);
	assign pos_sum  = neg_q ? (base_x + ring_x - rem_x) : (base_x + rem_x);
	assign pos_red  = (pos_sum >= ring_x) ? (pos_sum - ring_x) : pos_sum;
	assign pos_next = pos_red[tsrs_pkg::POS_W-1:0];

	assign walk_len = neg_q ? '0 :
		((mag_q < tsrs_pkg::TIME_BITS'(ring_eff)) ? mag_q[tsrs_pkg::RING_W-1:0] : ring_eff);
	assign walk_p_next = (walk_p_q == ring_m1) ? '0 : (walk_p_q + 1'b1);

	assign out_free   = !out_valid_q || item_out.ready;
	assign empty_ring = !has_q || !valid_q[last_q];

	always_comb begin
		ram_raddr = last_q;
		ram_waddr = pos_q;
		ram_we    = 1'b0;
		div_req   = '0;
		unique case (state_q)
			S_NORM: begin
				if (tsrs_pkg::RING_W'(last_q) >= ring_eff) begin
					div_req.start    = 1'b1;
					div_req.dividend = tsrs_pkg::TIME_BITS'(last_q);
					div_req.divisor  = tsrs_pkg::IVL_W'(ring_eff);
				end
			end
			S_RDLAST: begin
				ram_waddr = '0;
				ram_we    = empty_ring && (op_q == tsrs_pkg::OP_STORE) && out_free;
			end
			S_CALC: begin
				if (!too_old) begin
					div_req.start    = 1'b1;
					div_req.dividend = step_mag;
					div_req.divisor  = ivl_eff;
				end
			end
			S_DIV1: begin
				if (div_rsp.done) begin
					div_req.start    = 1'b1;
					div_req.dividend = div_rsp.quotient;
					div_req.divisor  = tsrs_pkg::IVL_W'(ring_eff);
				end
			end
			S_POS: ram_raddr = pos_next;
			S_WALK: ram_raddr = walk_p_q;
			S_WRITE: ram_we = out_free;
			S_LKCHK: ram_raddr = pos_q;
			S_IDLE, S_MODL, S_LASTT, S_DIV2: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			ring_size_q  <= tsrs_pkg::RING_SIZE_RST;
			slot_ivl_q   <= tsrs_pkg::SLOT_IVL_RST;
			op_q         <= tsrs_pkg::OP_STORE;
			t_q          <= '0;
			v_q          <= '0;
			last_q       <= '0;
			has_q        <= 1'b0;
			valid_q      <= '0;
			last_t_q     <= '0;
			window_q     <= '0;
			min_t_q      <= '0;
			neg_q        <= 1'b0;
			mag_q        <= '0;
			pos_q        <= '0;
			walk_cnt_q   <= '0;
			walk_p_q     <= '0;
			rd_pend_s1   <= 1'b0;
			rd_addr_s1   <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= tsrs_pkg::ST_STORED;
			out_value_q  <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == tsrs_pkg::CFG_RING_SIZE) begin
					ring_size_q <= cfg_data[tsrs_pkg::RING_W-1:0];
				end else begin
					slot_ivl_q <= cfg_data[tsrs_pkg::IVL_W-1:0];
				end
			end
			if (out_valid_q && item_out.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (item_in.valid) begin
						op_q    <= item_in.opcode;
						t_q     <= item_in.sample_time;
						v_q     <= item_in.sample_value;
						state_q <= S_NORM;
					end
				end
				S_NORM: begin
					state_q <= div_req.start ? S_MODL : S_RDLAST;
				end
				S_MODL: begin
					if (div_rsp.done) begin
						last_q  <= div_rsp.remainder[tsrs_pkg::POS_W-1:0];
						state_q <= S_RDLAST;
					end
				end
				S_RDLAST: begin
					if (!empty_ring) begin
						state_q <= S_LASTT;
					end else if (out_free) begin
						out_valid_q  <= 1'b1;
						out_value_q  <= '0;
						state_q      <= S_IDLE;
						if (op_q == tsrs_pkg::OP_STORE) begin
							out_status_q <= tsrs_pkg::ST_STORED;
							valid_q[0]   <= 1'b1;
							last_q       <= '0;
							has_q        <= 1'b1;
						end else begin
							out_status_q <= tsrs_pkg::ST_MISS;
						end
					end
				end
				S_LASTT: begin
					last_t_q <= tm_rdata;
					window_q <= win_prod;
					state_q  <= S_CALC;
				end
				S_CALC: begin
					neg_q   <= diff[tsrs_pkg::TIME_BITS-1];
					min_t_q <= min_t;
					if (!too_old) begin
						state_q <= S_DIV1;
					end else if (out_free) begin
						out_valid_q  <= 1'b1;
						out_status_q <= tsrs_pkg::ST_TOO_OLD;
						out_value_q  <= '0;
						state_q      <= S_IDLE;
					end
				end
				S_DIV1: begin
					if (div_rsp.done) begin
						mag_q   <= div_rsp.quotient;
						state_q <= S_DIV2;
					end
				end
				S_DIV2: begin
					if (div_rsp.done) begin
						state_q <= S_POS;
					end
				end
				S_POS: begin
					pos_q      <= pos_next;
					walk_cnt_q <= walk_len;
					walk_p_q   <= last_q;
					rd_pend_s1 <= 1'b0;
					state_q    <= (op_q == tsrs_pkg::OP_LOOKUP) ? S_LKCHK : S_WALK;
				end
				S_WALK: begin
					rd_pend_s1 <= (walk_cnt_q != '0);
					rd_addr_s1 <= walk_p_q;
					if (walk_cnt_q != '0) begin
						walk_cnt_q <= walk_cnt_q - 1'b1;
						walk_p_q   <= walk_p_next;
					end
					if (rd_pend_s1 && valid_q[rd_addr_s1] && (tm_rdata < min_t_q)) begin
						valid_q[rd_addr_s1] <= 1'b0;
					end
					if (walk_cnt_q == '0 && !rd_pend_s1) begin
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					if (out_free) begin
						valid_q[pos_q] <= 1'b1;
						last_q         <= pos_q;
						out_valid_q    <= 1'b1;
						out_status_q   <= tsrs_pkg::ST_STORED;
						out_value_q    <= '0;
						state_q        <= S_IDLE;
					end
				end
				S_LKCHK: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
						if (valid_q[pos_q] && (tm_rdata == t_q)) begin
							out_status_q <= tsrs_pkg::ST_FOUND;
							out_value_q  <= wd_rdata;
						end else begin
							out_status_q <= tsrs_pkg::ST_MISS;
							out_value_q  <= '0;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	tsrs_ram #(
		.WIDTH(tsrs_pkg::TIME_BITS),
		.DEPTH(tsrs_pkg::SLOTS)
	) u_time_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(t_q),
		.raddr(ram_raddr),
		.rdata(tm_rdata)
	);

	tsrs_ram #(
		.WIDTH(tsrs_pkg::WORD_W),
		.DEPTH(tsrs_pkg::SLOTS)
	) u_word_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(v_q),
		.raddr(ram_raddr),
		.rdata(wd_rdata)
	);

	tsrs_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	assign item_in.ready      = (state_q == S_IDLE);
	assign item_out.valid     = out_valid_q;
	assign item_out.status    = out_status_q;
	assign item_out.value_out = out_value_q;

	a_div_idle_at_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");

	a_last_in_ring: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RDLAST) |-> (tsrs_pkg::RING_W'(last_q) < ring_eff))
		else $error("last position outside the ring");

	a_pos_in_ring: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WRITE || state_q == S_LKCHK) |->
		(tsrs_pkg::RING_W'(pos_q) < ring_eff))
		else $error("target slot outside the ring");

	a_walk_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> (walk_cnt_q <= ring_eff))
		else $error("stale walk longer than the ring");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !item_out.ready) |=> out_valid_q)
		else $error("held result dropped");

endmodule

// ===== rtl/tsrs_ram.sv =====
// Generic single write port, single read port RAM with a registered read.
// No dependencies.
module tsrs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/tsrs_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by all divisions of
// the ring store. Depends on tsrs_pkg for widths and the request types.
module tsrs_div (
	input  logic               clk,
	input  logic               arst_n,
	input  tsrs_pkg::div_req_t req,
	output tsrs_pkg::div_rsp_t rsp
);

	logic [tsrs_pkg::TIME_BITS-1:0] quo_q;
	logic [tsrs_pkg::IVL_W-1:0]     rem_q;
	logic [tsrs_pkg::IVL_W-1:0]     dsr_q;
	logic [tsrs_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           busy_q;
	logic                           done_q;
	logic [tsrs_pkg::IVL_W:0]       rem_sh;
	logic                           fits;
	logic [tsrs_pkg::IVL_W:0]       rem_nx;

	assign rem_sh = {rem_q, quo_q[tsrs_pkg::TIME_BITS-1]};
	assign fits   = rem_sh >= {1'b0, dsr_q};
	assign rem_nx = fits ? (rem_sh - {1'b0, dsr_q}) : rem_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quo_q  <= '0;
			rem_q  <= '0;
			dsr_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				quo_q  <= req.dividend;
				rem_q  <= '0;
				dsr_q  <= req.divisor;
				cnt_q  <= tsrs_pkg::DIV_CNT_W'(tsrs_pkg::TIME_BITS - 1);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				quo_q <= {quo_q[tsrs_pkg::TIME_BITS-2:0], fits};
				rem_q <= rem_nx[tsrs_pkg::IVL_W-1:0];
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.busy      = busy_q;
	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule
